// ===== rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit named allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int MODE_W = 2;
  localparam int KEY_W  = 32;
  localparam int SIZE_W = 17;
  localparam int OUT_W  = 17;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_PRINT = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_MATCH,
    ST_ALLOC,
    ST_FREE,
    ST_EMIT
  } state_t;

  // strobes from the sequencer to every cell of the block list
  typedef struct packed {
    logic cap_fit;
    logic cap_match;
    logic ins;
    logic rem;
  } ffa_ctl_t;

endpackage

// ===== rtl/ffa_cell.sv =====
// ----------------------------------------------------------------------------
// ffa_cell
// One entry of the start-sorted block list: gap check, start match, shift.
// ----------------------------------------------------------------------------
module ffa_cell import ffa_pkg::*; #(
  parameter int MEM_WORDS = 65536,
  parameter int AW        = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_ctl_t          ctl,
  input  logic              ge,
  input  logic              sel,
  input  logic [SIZE_W-1:0] size,
  input  logic [AW-1:0]     faddr,
  input  logic              left_valid,
  input  logic [AW-1:0]     left_start,
  input  logic [AW-1:0]     left_stop,
  input  logic              right_valid,
  input  logic [AW-1:0]     right_start,
  input  logic [AW-1:0]     right_stop,
  output logic              blk_valid,
  output logic [AW-1:0]     blk_start,
  output logic [AW-1:0]     blk_stop,
  output logic              fit,
  output logic              bad,
  output logic              match,
  output logic [AW-1:0]     cand
);

  localparam int SW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;

  logic          valid_r, valid_nxt;
  logic [AW-1:0] start_r, start_nxt, stop_r, stop_nxt;
  logic          fit_r, bad_r, match_r;
  logic [SW-1:0] sum, sum1, lim;
  logic          fit_nxt, bad_nxt;

  always_comb begin
    sum     = SW'(left_stop) + SW'(size);
    sum1    = SW'(left_stop) + SW'(1);
    lim     = SW'(MEM_WORDS + 1);
    // terminal gap only in the first empty cell
    fit_nxt = valid_r ? (SW'(start_r) > sum) : (left_valid && (lim > sum));
    bad_nxt = sum1 > SW'(MEM_WORDS);
  end

  always_comb begin
    valid_nxt = valid_r;
    start_nxt = start_r;
    stop_nxt  = stop_r;
    if (ctl.ins) begin
      if (sel) begin
        valid_nxt = 1'b1;
        start_nxt = sum1[AW-1:0];
        stop_nxt  = sum[AW-1:0];
      end else if (ge) begin
        valid_nxt = left_valid;
        start_nxt = left_start;
        stop_nxt  = left_stop;
      end
    end else if (ctl.rem && ge) begin
      valid_nxt = right_valid;
      start_nxt = right_start;
      stop_nxt  = right_stop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    start_r <= start_nxt;
    stop_r  <= stop_nxt;
    if (ctl.cap_fit) begin
      fit_r <= fit_nxt;
      bad_r <= bad_nxt;
    end
    if (ctl.cap_match) begin
      match_r <= valid_r && (start_r == faddr);
    end
  end

  assign blk_valid = valid_r;
  assign blk_start = start_r;
  assign blk_stop  = stop_r;
  assign fit       = fit_r;
  assign bad       = bad_r;
  assign match     = match_r;
  assign cand      = sum1[AW-1:0];

endmodule

// ===== rtl/first_fit_named_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_named_allocator_core
// First-fit allocator with a name table over a row of block-list cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): mode, 32-bit name key, block size.
// Allocate places the block in the lowest gap that fits and records its start
// under the name (0 if nothing fits); free releases the name's block; print
// returns the name's address on the output channel (out_valid/out_stall).
// Only print produces a transfer on the output channel.
// Every cell of the block list checks its own gap in parallel; the sequencer
// then picks the first hit and the whole row shifts in one step.
// The sequencer steps allocate through name lookup and placement, free
// through name lookup, the name address memory read, the cell compare and
// the shift, and print through name lookup and the memory read before the
// result is loaded into the output register. Other modes end after lookup.
// One item is worked on at a time; the next is taken while a print result
// still waits in the output register. If the receiver stalls, the result
// holds and a following print waits for the register to drain.
// Reset empties the block list and the name table at once; no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_named_allocator_core import ffa_pkg::*; #(
  parameter int MEM_WORDS  = 65536,
  parameter int MAX_BLOCKS = 64,
  parameter int NAME_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [KEY_W-1:0]  in_var_name,
  input  logic [SIZE_W-1:0] in_block_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_address
);

  localparam int AW = $clog2(MEM_WORDS + 2);
  localparam int NW = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;

  state_t state_r, state_nxt;
  ffa_ctl_t ctl;

  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] size_r;

  // name table
  logic [NAME_SLOTS-1:0] name_valid_r;
  logic [KEY_W-1:0]      name_key_r [NAME_SLOTS];
  logic [AW-1:0]         name_mem [NAME_SLOTS];
  logic [AW-1:0]         rd_r;
  logic [NAME_SLOTS-1:0] hit_vec, fs_oh;
  logic [NW-1:0]         hit_idx, fs_idx, hit_idx_r, fs_idx_r;
  logic                  hit_r, fs_any_r;
  logic                  nm_we;
  logic [NW-1:0]         nm_widx;
  logic [AW-1:0]         nm_wdata;

  // block list
  logic [MAX_BLOCKS-1:0] c_valid, c_fit, c_bad, c_match, flag_vec, ge, sel;
  logic [AW-1:0]         c_start [MAX_BLOCKS];
  logic [AW-1:0]         c_stop  [MAX_BLOCKS];
  logic [AW-1:0]         c_cand  [MAX_BLOCKS];
  logic [AW-1:0]         cand_sel;
  logic                  bad_sel, any_flag, place_ok;

  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_addr_r;
  logic                  out_load, in_xfer;

  assign in_xfer = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // ---------------- name lookup ----------------
  genvar g;
  generate
    for (g = 0; g < NAME_SLOTS; g++) begin : g_nm
      assign hit_vec[g] = name_valid_r[g] && (name_key_r[g] == key_r);
      if (g == 0) begin : g_first
        assign fs_oh[g] = !name_valid_r[g];
      end else begin : g_rest
        assign fs_oh[g] = !name_valid_r[g] && (&name_valid_r[g-1:0]);
      end
    end
  endgenerate

  always_comb begin
    hit_idx = '0;
    fs_idx  = '0;
    for (int i = 0; i < NAME_SLOTS; i++) begin
      if (hit_vec[i]) hit_idx = hit_idx | NW'(i);
      if (fs_oh[i])   fs_idx  = fs_idx | NW'(i);
    end
  end

  // ---------------- cell row ----------------
  assign flag_vec = (state_r == ST_FREE) ? c_match : c_fit;
  assign any_flag = |flag_vec;

  generate
    for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      assign ge[g] = |flag_vec[g:0];
      if (g == 0) begin : g_first
        assign sel[g] = flag_vec[g];
      end else begin : g_rest
        assign sel[g] = flag_vec[g] && !ge[g-1];
      end
    end
  endgenerate

  generate
    for (g = 0; g < MAX_BLOCKS; g++) begin : g_row
      logic          lv, rv;
      logic [AW-1:0] ls, le, rs, re;
      if (g == 0) begin : g_l0
        assign lv = 1'b1;
        assign ls = '0;
        assign le = '0;
      end else begin : g_ln
        assign lv = c_valid[g-1];
        assign ls = c_start[g-1];
        assign le = c_stop[g-1];
      end
      if (g == MAX_BLOCKS - 1) begin : g_rl
        assign rv = 1'b0;
        assign rs = '0;
        assign re = '0;
      end else begin : g_rn
        assign rv = c_valid[g+1];
        assign rs = c_start[g+1];
        assign re = c_stop[g+1];
      end
      ffa_cell #(
        .MEM_WORDS(MEM_WORDS),
        .AW       (AW)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .ge         (ge[g]),
        .sel        (sel[g]),
        .size       (size_r),
        .faddr      (rd_r),
        .left_valid (lv),
        .left_start (ls),
        .left_stop  (le),
        .right_valid(rv),
        .right_start(rs),
        .right_stop (re),
        .blk_valid  (c_valid[g]),
        .blk_start  (c_start[g]),
        .blk_stop   (c_stop[g]),
        .fit        (c_fit[g]),
        .bad        (c_bad[g]),
        .match      (c_match[g]),
        .cand       (c_cand[g])
      );
    end
  endgenerate

  always_comb begin
    cand_sel = '0;
    bad_sel  = 1'b0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (sel[i]) begin
        cand_sel = cand_sel | c_cand[i];
        bad_sel  = bad_sel | c_bad[i];
      end
    end
  end

  // a full list refuses even an interior gap
  assign place_ok = any_flag && !c_valid[MAX_BLOCKS-1] && !bad_sel;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_LOOK;
      ST_LOOK: begin
        case (mode_r)
          MODE_ALLOC: state_nxt = ST_ALLOC;
          MODE_FREE:  state_nxt = ST_READ;
          MODE_PRINT: state_nxt = ST_READ;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_READ:  state_nxt = (mode_r == MODE_FREE) ? ST_MATCH : ST_EMIT;
      ST_MATCH: state_nxt = ST_FREE;
      ST_ALLOC: state_nxt = ST_IDLE;
      ST_FREE:  state_nxt = ST_IDLE;
      ST_EMIT:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.cap_fit   = (state_r == ST_LOOK);
    ctl.cap_match = (state_r == ST_MATCH);
    ctl.ins       = (state_r == ST_ALLOC) && (hit_r || fs_any_r) && place_ok;
    ctl.rem       = (state_r == ST_FREE) && hit_r && (rd_r != '0) && any_flag;
    nm_we    = 1'b0;
    nm_widx  = hit_idx_r;
    nm_wdata = '0;
    case (state_r)
      ST_ALLOC: begin
        nm_we    = hit_r || fs_any_r;
        nm_widx  = hit_r ? hit_idx_r : fs_idx_r;
        nm_wdata = place_ok ? cand_sel : '0;
      end
      ST_FREE: begin
        nm_we = hit_r && (rd_r != '0);
      end
      default: begin
        nm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      name_valid_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_ALLOC) && !hit_r && fs_any_r) begin
        name_valid_r[fs_idx_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= in_mode;
      key_r  <= in_var_name;
      size_r <= in_block_size;
    end
    if (state_r == ST_LOOK) begin
      hit_r     <= |hit_vec;
      hit_idx_r <= hit_idx;
      fs_any_r  <= |fs_oh;
      fs_idx_r  <= fs_idx;
    end
    if ((state_r == ST_ALLOC) && !hit_r && fs_any_r) begin
      name_key_r[fs_idx_r] <= key_r;
    end
    if (out_load) begin
      out_addr_r <= hit_r ? OUT_W'(rd_r) : '0;
    end
  end

  // name address memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (nm_we) begin
      name_mem[nm_widx] <= nm_wdata;
    end
    if (state_r == ST_READ) begin
      rd_r <= name_mem[hit_idx_r];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_address = out_addr_r;

endmodule

// ===== rtl/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks for the first-fit named allocator, bound to the top.
// ----------------------------------------------------------------------------
module ffa_checker import ffa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [MODE_W-1:0] in_mode,
  input logic [KEY_W-1:0]  in_var_name,
  input logic [SIZE_W-1:0] in_block_size,
  input logic              out_valid,
  input logic              out_stall,
  input logic [OUT_W-1:0]  out_address
);

  // one item at a time: the cycle after a transfer the input is held off
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // a result never appears straight out of idle
  a_result_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_address))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable({in_mode, in_var_name, in_block_size}))
    else $error("stalled input changed");

endmodule

bind first_fit_named_allocator_core ffa_checker u_ffa_checker (.*);
